/* hdl/isc_pkg.sv */
// Shared types, constants and helper functions for the IP status cache.
// No dependencies; every other file in hdl/ but isc_checker refers to this package by scoped names.
package isc_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 1024;
  localparam int unsigned HASH_SHIFT        = 12;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam logic [31:0] LIFETIME_RST      = 32'd3600;
  localparam logic [31:0] COUNT_MAX         = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_STORE  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [31:0] value;
    logic [31:0] now;
    logic [32:0] expiry;
  } item_t;

  // One table slot.
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] value;
    logic [32:0] expiry;
  } entry_t;

  // Byte-swap the address and add the swapped value shifted down.
  function automatic logic [31:0] slot_hash(input logic [31:0] a);
    logic [31:0] swapped;
    swapped = {a[7:0], a[15:8], a[23:16], a[31:24]};
    return (swapped >> HASH_SHIFT) + swapped;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == COUNT_MAX) ? c : c + 32'd1;
  endfunction

endpackage

/* hdl/ip_status_cache_with_expiry.sv */
// Top level of the IP status cache. A store or lookup is queued, then the back
// reads its slot and updates it as needed before it pops the next word; the queue
// takes new words meanwhile. Unused op and clear results skip the slot access.
// Reset and clear each run a sweep over all TABLE_ENTRIES slots of the slot memory;
// busy stays high meanwhile. Results cannot be stalled by the receiver.
// Depends on isc_pkg, isc_front, isc_fifo, isc_back.
module ip_status_cache_with_expiry #(
  parameter int unsigned TABLE_ENTRIES = isc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic [31:0]        in_ip_address,
  input  logic signed [31:0] in_status_value,
  input  logic [31:0]        in_current_time,
  // result channel
  output logic               out_strobe,
  output logic signed [31:0] out_found_value,
  output logic               out_hit,
  output logic [31:0]        out_hit_count,
  output logic [31:0]        out_fill_count,
  output logic [31:0]        out_collision_count,
  // configuration: cache lifetime
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_lifetime
);

  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned DATA_W = IDX_W + $bits(isc_pkg::item_t);

  logic [31:0]          lifetime_r, lifetime_nxt;

  logic                 push;
  isc_pkg::item_t       push_item;
  logic [IDX_W-1:0]     push_idx;

  logic [DATA_W-1:0]    head_data;
  isc_pkg::item_t       q_item;
  logic [IDX_W-1:0]     q_idx;
  logic                 q_empty;
  logic                 q_full;
  logic                 pop;
  logic                 clearing;

  // The lifetime register takes a word whenever offered.
  assign cfg_ready    = 1'b1;
  assign lifetime_nxt = (cfg_valid && cfg_ready) ? cfg_lifetime : lifetime_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= isc_pkg::LIFETIME_RST;
    end else begin
      lifetime_r <= lifetime_nxt;
    end
  end

  // Hold off new words while the queue is full or the table is being swept.
  assign busy = q_full || clearing;

  // Front: decode op, hash the address to a slot, form the expiry time.
  isc_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_ip_address   (in_ip_address),
    .in_status_value (in_status_value),
    .in_current_time (in_current_time),
    .lifetime        (lifetime_r),
    .push            (push),
    .push_item       (push_item),
    .push_idx        (push_idx)
  );

  // Queue: decouple the front from the read-modify-write in the back.
  isc_fifo #(
    .DATA_W (DATA_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_idx, push_item}),
    .pop       (pop),
    .head_data (head_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign q_idx  = head_data[DATA_W-1 -: IDX_W];
  assign q_item = isc_pkg::item_t'(head_data[$bits(isc_pkg::item_t)-1:0]);

  // Back: read the slot, update counters and slot, drive the result word.
  isc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_item              (q_item),
    .q_idx               (q_idx),
    .pop                 (pop),
    .clearing            (clearing),
    .out_strobe          (out_strobe),
    .out_found_value     (out_found_value),
    .out_hit             (out_hit),
    .out_hit_count       (out_hit_count),
    .out_fill_count      (out_fill_count),
    .out_collision_count (out_collision_count)
  );

endmodule

/* hdl/isc_front.sv */
// Front end of the IP status cache: decodes the op, forms the slot index
// and the expiry time of each accepted word. Depends on isc_pkg.
module isc_front #(
  parameter int unsigned TABLE_ENTRIES = isc_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          in_op,
  input  logic [31:0]         in_ip_address,
  input  logic signed [31:0]  in_status_value,
  input  logic [31:0]         in_current_time,
  input  logic [31:0]         lifetime,
  output logic                push,
  output isc_pkg::item_t      push_item,
  output logic [IDX_W-1:0]    push_idx
);

  logic [31:0] hash;

  assign push = start && !busy;
  assign hash = isc_pkg::slot_hash(in_ip_address);

  // Mask to the table size; the result is always below TABLE_ENTRIES.
  assign push_idx = hash[IDX_W-1:0] & IDX_W'(TABLE_ENTRIES - 1);

  always_comb begin
    push_item.op     = isc_pkg::op_t'(in_op);
    push_item.addr   = in_ip_address;
    push_item.value  = in_status_value;
    push_item.now    = in_current_time;
    push_item.expiry = {1'b0, in_current_time} + {1'b0, lifetime};
  end

endmodule

/* hdl/isc_fifo.sv */
// Short queue between the front and back ends of the IP status cache.
// Depth comes from isc_pkg::QUEUE_DEPTH.
module isc_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output logic              empty,
  output logic              full
);

  localparam int unsigned DEPTH = isc_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]    count_r, count_nxt;

  assign empty     = (count_r == '0);
  assign full      = (count_r == (PTR_W+1)'(DEPTH));
  assign head_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (PTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/isc_back.sv */
// Back end of the IP status cache: owns the slot memory and the counters,
// runs read-modify-write per store or lookup word and the clearing sweep. Depends on isc_pkg.
module isc_back #(
  parameter int unsigned TABLE_ENTRIES = isc_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  isc_pkg::item_t     q_item,
  input  logic [IDX_W-1:0]   q_idx,
  output logic               pop,
  output logic               clearing,
  output logic               out_strobe,
  output logic signed [31:0] out_found_value,
  output logic               out_hit,
  output logic [31:0]        out_hit_count,
  output logic [31:0]        out_fill_count,
  output logic [31:0]        out_collision_count
);

  isc_pkg::bk_state_t state_r, state_nxt;
  isc_pkg::item_t     item_r, item_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [31:0]        hits_r, hits_nxt;
  logic [31:0]        fills_r, fills_nxt;
  logic [31:0]        colls_r, colls_nxt;
  logic               strobe_r, strobe_nxt;
  logic [31:0]        found_r, found_nxt;
  logic               hit_r, hit_nxt;

  isc_pkg::entry_t    mem [TABLE_ENTRIES];
  isc_pkg::entry_t    rd_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  isc_pkg::entry_t    mem_wdata;

  logic               clr_last;

  assign clr_last = (clr_idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign pop      = (state_r == isc_pkg::BK_IDLE) && !q_empty;
  assign clearing = (state_r == isc_pkg::BK_CLEAR);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      isc_pkg::BK_CLEAR: begin
        if (clr_last) state_nxt = isc_pkg::BK_IDLE;
      end
      isc_pkg::BK_IDLE: begin
        if (!q_empty) begin
          case (q_item.op)
            isc_pkg::OP_CLEAR:  state_nxt = isc_pkg::BK_CLEAR;
            isc_pkg::OP_STORE:  state_nxt = isc_pkg::BK_EXEC;
            isc_pkg::OP_LOOKUP: state_nxt = isc_pkg::BK_EXEC;
            default:            state_nxt = isc_pkg::BK_IDLE;
          endcase
        end
      end
      isc_pkg::BK_EXEC: state_nxt = isc_pkg::BK_IDLE;
      default:          state_nxt = isc_pkg::BK_CLEAR;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    item_nxt    = item_r;
    idx_nxt     = idx_r;
    clr_idx_nxt = clr_idx_r;
    hits_nxt    = hits_r;
    fills_nxt   = fills_r;
    colls_nxt   = colls_r;
    strobe_nxt  = 1'b0;
    found_nxt   = '0;
    hit_nxt     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx_r;
    mem_wdata   = '0;
    case (state_r)
      isc_pkg::BK_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        clr_idx_nxt = clr_last ? '0 : clr_idx_r + IDX_W'(1);
      end
      isc_pkg::BK_IDLE: begin
        if (!q_empty) begin
          item_nxt = q_item;
          idx_nxt  = q_idx;
          case (q_item.op)
            isc_pkg::OP_CLEAR: begin
              // Report zeroed counters now; the sweep follows.
              hits_nxt    = '0;
              fills_nxt   = '0;
              colls_nxt   = '0;
              clr_idx_nxt = '0;
              strobe_nxt  = 1'b1;
            end
            isc_pkg::OP_NONE: strobe_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      isc_pkg::BK_EXEC: begin
        strobe_nxt = 1'b1;
        case (item_r.op)
          isc_pkg::OP_STORE: begin
            if (rd_r.addr == '0) begin
              fills_nxt = isc_pkg::sat_inc(fills_r);
            end else if (rd_r.addr != item_r.addr) begin
              colls_nxt = isc_pkg::sat_inc(colls_r);
            end
            mem_we           = 1'b1;
            mem_wdata.addr   = item_r.addr;
            mem_wdata.value  = item_r.value;
            mem_wdata.expiry = item_r.expiry;
          end
          isc_pkg::OP_LOOKUP: begin
            if ({1'b0, item_r.now} > rd_r.expiry) begin
              // Expired: empty the address, keep value and expiry.
              mem_we           = 1'b1;
              mem_wdata.addr   = '0;
              mem_wdata.value  = rd_r.value;
              mem_wdata.expiry = rd_r.expiry;
            end else if (rd_r.addr == item_r.addr) begin
              hits_nxt  = isc_pkg::sat_inc(hits_r);
              found_nxt = rd_r.value;
              hit_nxt   = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= isc_pkg::BK_CLEAR;
      clr_idx_r <= '0;
      hits_r    <= '0;
      fills_r   <= '0;
      colls_r   <= '0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      hits_r    <= hits_nxt;
      fills_r   <= fills_nxt;
      colls_r   <= colls_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    hit_r   <= hit_nxt;
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[q_idx];
  end

  assign out_strobe          = strobe_r;
  assign out_found_value     = $signed(found_r);
  assign out_hit             = hit_r;
  assign out_hit_count       = hits_r;
  assign out_fill_count      = fills_r;
  assign out_collision_count = colls_r;

endmodule

/* hdl/isc_checker.sv */
// Port-level checks for the IP status cache, bound to the top level.
// Depends only on the ports of ip_status_cache_with_expiry.
module isc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_strobe,
  input logic signed [31:0] out_found_value,
  input logic               out_hit,
  input logic [31:0]        out_hit_count
);

  // A hit is only reported on a result word.
  a_hit_on_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_hit |-> out_strobe)
    else $error("hit without result strobe");

  // A miss returns zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_hit) |-> (out_found_value == 32'sd0))
    else $error("nonzero value on a miss");

  // A hit has always been counted.
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_hit) |-> (out_hit_count != 32'd0))
    else $error("hit reported with zero hit count");

  // Reset starts the clearing sweep: busy, no result.
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> (busy && !out_strobe))
    else $error("block not busy or strobing right after reset");

endmodule

bind ip_status_cache_with_expiry isc_checker u_isc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_found_value (out_found_value),
  .out_hit         (out_hit),
  .out_hit_count   (out_hit_count)
);

/* test/tb_ip_status_cache_with_expiry.sv */
// Self-checking testbench for the IP status cache with expiry: drives store,
// lookup and clear commands, mirrors the slot table and counters, checks every result.
// Depends on isc_pkg and ip_status_cache_with_expiry from hdl/.
module tb_ip_status_cache_with_expiry;
  import isc_pkg::*;

  // Abort when nothing moves for this long. A clear or reset sweep covers all
  // TABLE_ENTRIES_DEF slots, and sender gaps come on top of that.
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned REPORT_MAX = 10;
  localparam int unsigned POOL_MAX = 48;

  // One result word as the block presents it.
  typedef struct packed {
    logic signed [31:0] found;
    logic               hit;
    logic [31:0]        hits;
    logic [31:0]        fills;
    logic [31:0]        collisions;
  } cache_status_t;

  // Mirror of the slot table and counters; predicts one status word per command
  // and holds those words until the block returns them.
  class cache_mirror;
    logic [31:0]   lifetime;
    logic [31:0]   slot_addr   [TABLE_ENTRIES_DEF];
    logic [31:0]   slot_value  [TABLE_ENTRIES_DEF];
    logic [32:0]   slot_expiry [TABLE_ENTRIES_DEF];
    logic [31:0]   hits_total;
    logic [31:0]   fills_total;
    logic [31:0]   collisions_total;
    cache_status_t expected_status[$];
    int unsigned   mismatches;

    function new();
      lifetime   = LIFETIME_RST;
      mismatches = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
        slot_addr[i]   = '0;
        slot_value[i]  = '0;
        slot_expiry[i] = '0;
      end
      hits_total       = '0;
      fills_total      = '0;
      collisions_total = '0;
    endfunction

    // Add one unless already all ones.
    function logic [31:0] bump(logic [31:0] c);
      return c + {31'd0, ~&c};
    endfunction

    function int unsigned slot_of(logic [31:0] a);
      logic [31:0] swapped;
      swapped = {a[7:0], a[15:8], a[23:16], a[31:24]};
      return (swapped + (swapped >> HASH_SHIFT)) % TABLE_ENTRIES_DEF;
    endfunction

    function void note_command(op_t op, logic [31:0] addr, logic [31:0] value,
                               logic [31:0] now);
      int unsigned   i;
      cache_status_t st;
      i  = slot_of(addr);
      st = '0;
      case (op)
        OP_STORE: begin
          if (slot_addr[i] == 32'd0)
            fills_total = bump(fills_total);
          else if (slot_addr[i] != addr)
            collisions_total = bump(collisions_total);
          slot_addr[i]   = addr;
          slot_value[i]  = value;
          slot_expiry[i] = {1'b0, now} + {1'b0, lifetime};
        end
        OP_LOOKUP: begin
          if ({1'b0, now} > slot_expiry[i]) begin
            slot_addr[i] = 32'd0;
          end else if (slot_addr[i] == addr) begin
            hits_total = bump(hits_total);
            st.found   = slot_value[i];
            st.hit     = 1'b1;
          end
        end
        OP_CLEAR: wipe();
        default: ;
      endcase
      st.hits       = hits_total;
      st.fills      = fills_total;
      st.collisions = collisions_total;
      expected_status.push_back(st);
    endfunction

    function void check_status(logic signed [31:0] found, logic hit, logic [31:0] hits,
                               logic [31:0] fills, logic [31:0] collisions);
      cache_status_t want;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result word: found=%0d hit=%0b hits=%0d fills=%0d coll=%0d",
                   found, hit, hits, fills, collisions);
        return;
      end
      want = expected_status.pop_front();
      if (found !== want.found || hit !== want.hit || hits !== want.hits ||
          fills !== want.fills || collisions !== want.collisions) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("mismatch: expected found=%0d hit=%0b hits=%0d fills=%0d coll=%0d",
                   want.found, want.hit, want.hits, want.fills, want.collisions);
          $display("          actual   found=%0d hit=%0b hits=%0d fills=%0d coll=%0d",
                   found, hit, hits, fills, collisions);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_op = OP_NONE;
  logic [31:0]        in_ip_address = '0;
  logic signed [31:0] in_status_value = '0;
  logic [31:0]        in_current_time = '0;
  logic               out_strobe;
  logic signed [31:0] out_found_value;
  logic               out_hit;
  logic [31:0]        out_hit_count;
  logic [31:0]        out_fill_count;
  logic [31:0]        out_collision_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [31:0]        cfg_lifetime = '0;

  cache_mirror mirror;
  logic [31:0] stored_addrs[$];       // recent store keys, reused for hits and collisions
  logic [31:0] clock_base = 32'd5000; // advancing notion of "now" for the random part
  int unsigned quiet_cycles = 0;

  ip_status_cache_with_expiry u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_ip_address       (in_ip_address),
    .in_status_value     (in_status_value),
    .in_current_time     (in_current_time),
    .out_strobe          (out_strobe),
    .out_found_value     (out_found_value),
    .out_hit             (out_hit),
    .out_hit_count       (out_hit_count),
    .out_fill_count      (out_fill_count),
    .out_collision_count (out_collision_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_lifetime        (cfg_lifetime)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check every result word at the edge that ends its strobe cycle.
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      mirror.check_status(out_found_value, out_hit, out_hit_count, out_fill_count,
                          out_collision_count);
  end

  // Watchdog: restart the count on any accepted word, result or register write.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no activity for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one command word, idle first with the given chance per cycle,
  // then hold it until the block takes it. Leave start high afterwards so
  // back-to-back words need no second assignment in the same step.
  task automatic send_command(input op_t op, input logic [31:0] addr,
                              input logic [31:0] value, input logic [31:0] now,
                              input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_op           <= op;
    in_ip_address   <= addr;
    in_status_value <= value;
    in_current_time <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    mirror.note_command(op, addr, value, now);
  endtask

  // Drop start, drain every expected word, wait out any clearing sweep,
  // then give the block time to go idle.
  task automatic settle();
    start <= 1'b0;
    while (mirror.expected_status.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_lifetime(input logic [31:0] lifetime);
    settle();
    cfg_lifetime <= lifetime;
    cfg_valid    <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid       <= 1'b0;
    mirror.lifetime  = lifetime;
  endtask

  // Prefer recently stored keys so lookups hit; a low-byte flip keeps the slot
  // but changes the key, which forces collisions and lookup misses.
  function automatic logic [31:0] pick_address();
    int unsigned r;
    logic [31:0] key;
    r = $urandom_range(99);
    if (stored_addrs.size() != 0)
      key = stored_addrs[$urandom_range(stored_addrs.size() - 1)];
    else
      key = $urandom;
    if (r < 55)
      return key;
    if (r < 70)
      return key ^ {24'd0, 8'($urandom_range(255, 1))};
    if (r < 75)
      return 32'd0;
    return $urandom;
  endfunction

  // Directed words under the reset lifetime of 3600. Key 0x55 shares slot 0
  // with key zero, which lets the empty-slot cases meet each other.
  task automatic run_directed();
    // lookup of key zero on a fresh, unexpired empty slot hits with value 0
    send_command(OP_LOOKUP, 32'd0, 32'd0, 32'd0, 0);
    send_command(OP_NONE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    send_command(OP_STORE, 32'h0000_0055, 32'h7FFF_FFFF, 32'd100, 0);
    // last unexpired instant, then one past it empties the slot
    send_command(OP_LOOKUP, 32'h0000_0055, 32'd0, 32'd3700, 0);
    send_command(OP_LOOKUP, 32'h0000_0055, 32'd0, 32'd3701, 0);
    // expiry and value survive emptying, so key zero now hits the old value
    send_command(OP_LOOKUP, 32'd0, 32'd0, 32'd3700, 0);
    // time at the top: expiry needs the 33rd bit
    send_command(OP_STORE, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_command(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 0);
    send_command(OP_STORE, 32'h0000_0066, 32'd1, 32'd200, 0);
    send_command(OP_STORE, 32'h0000_0077, 32'd2, 32'd200, 0);
    // storing key zero counts a collision and leaves the slot empty
    send_command(OP_STORE, 32'd0, 32'd5, 32'd200, 0);
    send_command(OP_STORE, 32'h0000_0088, 32'hFFFF_FFFF, 32'd200, 0);
    send_command(OP_LOOKUP, 32'h0000_0088, 32'd0, 32'd0, 0);
    send_command(OP_LOOKUP, 32'h0000_0077, 32'd0, 32'd300, 0);
    send_command(OP_STORE, 32'h1234_5678, 32'hFFFF_FFFF, 32'd0, 0);
    send_command(OP_LOOKUP, 32'h1234_5678, 32'd0, 32'hFFFF_FFFF, 0);
    send_command(OP_NONE, 32'd0, 32'h8000_0000, 32'd0, 0);
    send_command(OP_CLEAR, 32'hA5A5_5A5A, 32'h1234_5678, 32'h0F0F_F0F0, 0);
    send_command(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 32'd0, 0);
    send_command(OP_LOOKUP, 32'd0, 32'd0, 32'd0, 0);
    send_command(OP_STORE, 32'h00FF_00FF, 32'd0, 32'd0, 0);
    send_command(OP_LOOKUP, 32'h00FF_00FF, 32'd0, 32'd3600, 0);
  endtask

  // Random words under one lifetime. Time mostly creeps forward by up to
  // step_max per word; a few words use a wild time to jump expiry either way.
  task automatic run_phase(input logic [31:0] lifetime, input int unsigned idle_pct,
                           input int unsigned step_max, input int unsigned count);
    int unsigned r;
    op_t         op;
    logic [31:0] addr;
    logic [31:0] value;
    logic [31:0] now;
    write_lifetime(lifetime);
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(199);
      if (r < 84)
        op = OP_STORE;
      else if (r < 188)
        op = OP_LOOKUP;
      else if (r < 196)
        op = OP_NONE;
      else
        op = OP_CLEAR;
      addr = pick_address();
      if ($urandom_range(9) == 0)
        value = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else
        value = $urandom;
      clock_base = clock_base + $urandom_range(step_max);
      now = ($urandom_range(19) == 0) ? $urandom : clock_base;
      if (op == OP_STORE) begin
        stored_addrs.push_back(addr);
        if (stored_addrs.size() > POOL_MAX)
          void'(stored_addrs.pop_front());
      end
      // keep a burst without idling at the head of every 64 words
      send_command(op, addr, value, now, (n % 64 < 12) ? 0 : idle_pct);
    end
  endtask

  initial begin
    mirror = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    run_phase(32'd0,          84, 1,        300);
    run_phase(32'hFFFF_FFFF,  22, 1 << 24,  300);
    run_phase(32'd20,         0,  3,        300);
    run_phase($urandom_range(200, 1), 84, 5, 300);
    run_phase(LIFETIME_RST,   22, 40,       300);
    run_phase(32'd3600,       0,  40,       300);

    settle();
    if (mirror.mismatches == 0 && mirror.expected_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
